// ===== hdl/bdeq_pkg.sv =====
// Shared types, codes and lookup functions for the button debounce event queue.
package bdeq_pkg;

  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_NUM_SOURCES = 8;

  localparam int SRC_W      = 3;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CODE_W     = 3;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  // wide enough to hold NUM_SOURCES up to 32 for range checks
  localparam int SRC_CMP_W  = 6;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd60000;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET  = 32'd1000000;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

  typedef struct packed {
    logic              func;
    logic [SRC_W-1:0]  source;
    logic [TIME_W-1:0] time_us;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] edge_status;
    logic                event_valid;
    logic [CODE_W-1:0]   event_code;
    logic [COUNT_W-1:0]  queue_count;
  } rsp_t;

  // classified request handed from the front end to the back end
  typedef struct packed {
    logic              is_poll;
    logic              src_ok;
    logic [SRC_W-1:0]  source;
    logic [TIME_W-1:0] time_us;
  } cmd_t;

  // sel button and encoder switch share the select code
  function automatic logic [CODE_W-1:0] source_code(input logic [SRC_W-1:0] src);
    logic [CODE_W-1:0] code;
    unique case (src)
      3'd0:    code = 3'd0;
      3'd1:    code = 3'd1;
      3'd2:    code = 3'd1;
      3'd3:    code = 3'd2;
      3'd4:    code = 3'd3;
      3'd5:    code = 3'd4;
      3'd6:    code = 3'd5;
      3'd7:    code = 3'd6;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/button_debounce_event_queue.sv =====
// Top level: button debounce with event ring, queue-style request and result ports.
//
//  channel   ports                          takes a request when
//  --------  -----------------------------  -------------------------------
//  input     push, full, in_item (req_t)    push && !full
//  result    empty, pop, out_item (rsp_t)   pop && !empty
//  config    cfg_write, cfg_index, cfg_data cfg_write (no wait, no read-back)
//
// Edge requests and polls of an empty ring complete in the execute state; polls of a
// non-empty ring go on to a read state (the ring memory read is registered). A result
// is pushed into the result FIFO, from which it shows on the result ports, in the cycle
// its request is taken, or from the read state for a poll that finds an event, as long as the result FIFO has room.
// A two-entry FIFO on each side lets input and output stall independently;
// the back end starts a request only when the result FIFO has room.
// Reset (rst, synchronous) clears source times, phases, ring pointers and FIFOs;
// ring contents are not cleared.
module button_debounce_event_queue
  import bdeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  req_t                  in_item,
  output logic                  empty,
  input  logic                  pop,
  output rsp_t                  out_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TIME_W-1:0] debounce_window;
  logic [TIME_W-1:0] phase_timeout;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_full;
  logic res_push;
  rsp_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_window <= DEBOUNCE_RESET;
      phase_timeout   <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_window <= cfg_data;
        REG_TIMEOUT:  phase_timeout   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // front end: classify and buffer requests
  bdeq_front #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req       (in_item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back end: debounce state and event ring
  bdeq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_SOURCES (NUM_SOURCES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take),
    .debounce_window (debounce_window),
    .phase_timeout   (phase_timeout),
    .res_full        (res_full),
    .res_push        (res_push),
    .res             (res)
  );

  // result FIFO decouples the consumer from the back end
  bdeq_fifo #(
    .WIDTH ($bits(rsp_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .rdata (out_item)
  );

  // back end must never produce a result without room reserved for it
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full result FIFO");

  // a poll result carries no edge status
  a_poll_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.event_valid) |-> (out_item.edge_status == ST_IGNORED))
    else $error("event result with nonzero edge status");

  // no event means code zero
  a_no_code: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.event_valid) |-> (out_item.event_code == '0))
    else $error("event code set without event");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result FIFO not empty after reset");

endmodule

// ===== hdl/bdeq_fifo.sv =====
// Two-entry FIFO used for requests and results between the pipeline sections.
module bdeq_fifo
  import bdeq_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/bdeq_front.sv =====
// Front end: classifies incoming requests and buffers them for the back end.
module bdeq_front
  import bdeq_pkg::*;
#(
  parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t req,
  output logic full,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  cmd_t cmd_in;
  logic cmd_empty;

  // out-of-range sources are flagged here so the back end just skips them
  always_comb begin
    cmd_in.is_poll = (req.func == FUNC_POLL);
    cmd_in.src_ok  = (SRC_CMP_W'(req.source) < SRC_CMP_W'(NUM_SOURCES));
    cmd_in.source  = req.source;
    cmd_in.time_us = req.time_us;
  end

  bdeq_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_take),
    .empty (cmd_empty),
    .rdata (cmd)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// ===== hdl/bdeq_back.sv =====
// Back end: per-source debounce state, toggle phase and the event ring.
module bdeq_back
  import bdeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_take,
  input  logic [TIME_W-1:0] debounce_window,
  input  logic [TIME_W-1:0] phase_timeout,
  input  logic              res_full,
  output logic              res_push,
  output rsp_t              res
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR  = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] FULL_FILL = PW'(QUEUE_DEPTH - 1);

  localparam logic S_EXEC = 1'b0;
  localparam logic S_READ = 1'b1;

  logic              state;
  logic              state_next;

  logic [TIME_W-1:0] last_time [NUM_SOURCES];
  logic              phase [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] src_hit;
  logic [TIME_W-1:0] last_sel;
  logic              phase_sel;
  logic [TIME_W-1:0] dt;
  logic              pass;
  logic              new_phase;
  logic              src_we;

  logic [CODE_W-1:0] ring [QUEUE_DEPTH];
  logic [CODE_W-1:0] rd_data;
  logic [PW-1:0]     head;
  logic [PW-1:0]     head_next;
  logic [PW-1:0]     tail;
  logic [PW-1:0]     tail_next;
  logic [PW-1:0]     head_inc;
  logic [PW-1:0]     tail_inc;
  logic [PW-1:0]     fill;
  logic [PW-1:0]     fill_next;
  logic              ring_we;
  logic              ring_re;

  // source lookup
  always_comb begin
    last_sel  = '0;
    phase_sel = 1'b0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      src_hit[i] = (SRC_CMP_W'(cmd.source) == SRC_CMP_W'(i));
      if (src_hit[i]) begin
        last_sel  = last_time[i];
        phase_sel = phase[i];
      end
    end
  end

  assign dt        = cmd.time_us - last_sel;
  assign pass      = (dt >= debounce_window);
  // past the timeout the phase restarts from released, so it toggles to 1
  assign new_phase = (dt > phase_timeout) ? 1'b1 : ~phase_sel;

  assign head_inc = (head == LAST_PTR) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_PTR) ? '0 : tail + 1'b1;

  always_comb begin
    cmd_take   = (state == S_EXEC) && cmd_valid && !res_full;
    state_next = state;
    src_we     = 1'b0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    res_push   = 1'b0;
    res        = '0;
    unique case (state)
      S_EXEC: begin
        if (cmd_take) begin
          if (!cmd.is_poll) begin
            res_push        = 1'b1;
            res.edge_status = ST_IGNORED;
            if (cmd.src_ok && pass) begin
              src_we = 1'b1;
              if (!new_phase) begin
                res.edge_status = ST_RELEASED;
              end else if (fill != FULL_FILL) begin
                ring_we         = 1'b1;
                tail_next       = tail_inc;
                fill_next       = fill + 1'b1;
                res.edge_status = ST_QUEUED;
              end else begin
                res.edge_status = ST_DROPPED;
              end
            end
            res.queue_count = COUNT_W'(fill_next);
          end else if (fill != '0) begin
            // ring read is registered; result goes out next cycle
            ring_re    = 1'b1;
            head_next  = head_inc;
            fill_next  = fill - 1'b1;
            state_next = S_READ;
          end else begin
            res_push        = 1'b1;
            res.queue_count = COUNT_W'(fill);
          end
        end
      end
      S_READ: begin
        res_push        = 1'b1;
        res.event_valid = 1'b1;
        res.event_code  = rd_data;
        res.queue_count = COUNT_W'(fill);
        state_next      = S_EXEC;
      end
      default: begin
        state_next = S_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[tail] <= source_code(cmd.source);
    end
    if (ring_re) begin
      rd_data <= ring[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EXEC;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        last_time[i] <= '0;
        phase[i]     <= 1'b0;
      end
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
      if (src_we) begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          if (src_hit[i]) begin
            last_time[i] <= cmd.time_us;
            phase[i]     <= new_phase;
          end
        end
      end
    end
  end

endmodule
